>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication, live during reset.
`define ASSERT_NXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

>>> sv/ilms_pkg.sv
`default_nettype none

package ilms_pkg;

  localparam int MAX_PIXELS_LOG2 = 24;

  localparam int PIX_W   = 8;
  localparam int CNT_W   = MAX_PIXELS_LOG2 + 1;
  localparam int SUM_W   = MAX_PIXELS_LOG2 + PIX_W;
  localparam int SQ_W    = MAX_PIXELS_LOG2 + 2 * PIX_W;
  localparam int MEAN_W  = PIX_W;
  localparam int MSQ_W   = 2 * PIX_W;
  localparam int STD_W   = 15;
  localparam int FRAC_W  = 8;
  localparam int RAD_W   = MSQ_W + 2 * FRAC_W;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int DCNT_W  = $clog2(SQ_W);
  localparam int SCNT_W  = $clog2(ROOT_STEPS);
  localparam int JOB_DEPTH = 2;

  localparam logic [STD_W-1:0] STD_MAX = {STD_W{1'b1}};

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq_sum;
    logic             ovf;
  } job_t;

endpackage

`default_nettype wire

>>> sv/ilms_front.sv
`default_nettype none

module ilms_front
  import ilms_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [PIX_W-1:0] red,
  input  wire logic [PIX_W-1:0] green,
  input  wire logic [PIX_W-1:0] blue,
  input  wire logic             last_pixel,
  output      logic             job_push,
  output      job_t             job
);

  logic [PIX_W-1:0] hi, lo, light;
  logic [MSQ_W-1:0] light_sq;
  logic [CNT_W-1:0] count_r, count_nxt, count_acc;
  logic [SUM_W-1:0] sum_r, sum_nxt, sum_acc;
  logic [SQ_W-1:0]  sq_r, sq_nxt, sq_acc;
  logic             ovf_r, ovf_nxt, ovf_acc;

  always_comb begin
    hi = red;
    lo = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    light    = PIX_W'(((PIX_W+1)'(hi) + (PIX_W+1)'(lo)) >> 1);
    light_sq = MSQ_W'(light) * MSQ_W'(light);

    count_acc = count_r;
    sum_acc   = sum_r;
    sq_acc    = sq_r;
    ovf_acc   = ovf_r;
    if (!count_r[CNT_W-1]) begin
      count_acc = count_r + CNT_W'(1);
      sum_acc   = sum_r + SUM_W'(light);
      sq_acc    = sq_r + SQ_W'(light_sq);
    end else begin
      ovf_acc = 1'b1;
    end

    job.count  = count_acc;
    job.sum    = sum_acc;
    job.sq_sum = sq_acc;
    job.ovf    = ovf_acc;
    job_push   = accept && last_pixel;

    count_nxt = count_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      if (last_pixel) begin
        count_nxt = '0;
        sum_nxt   = '0;
        sq_nxt    = '0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = count_acc;
        sum_nxt   = sum_acc;
        sq_nxt    = sq_acc;
        ovf_nxt   = ovf_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/ilms_fifo.sv
`default_nettype none

module ilms_fifo
  import ilms_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t wr_job,
  input  wire logic pop,
  output      job_t rd_job,
  output      logic full,
  output      logic empty
);

  localparam int AW = $clog2(JOB_DEPTH);

  job_t              mem [JOB_DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]       fill_r, fill_nxt;
  logic              do_push, do_pop;

  always_comb begin
    full    = (fill_r == (AW+1)'(JOB_DEPTH));
    empty   = (fill_r == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    rd_job  = mem[rd_ptr_r];

    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) fill_nxt = fill_r + (AW+1)'(1);
    if (do_pop && !do_push) fill_nxt = fill_r - (AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/ilms_back.sv
`default_nettype none

module ilms_back
  import ilms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  input  wire job_t              job,
  output      logic              job_pop,
  input  wire logic              out_pop,
  output      logic              out_empty,
  output      logic [MEAN_W-1:0] out_mean,
  output      logic [STD_W-1:0]  out_std,
  output      logic              out_ovf
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_SUB,
    S_ROOT,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic               ovf_r, ovf_nxt, zero_r, zero_nxt, phase_r, phase_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [SQ_W-1:0]    dvd_r, dvd_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic [MEAN_W-1:0]  mean_r, mean_nxt;
  logic [MSQ_W-1:0]   msq_r, msq_nxt, meansq_r, meansq_nxt;
  logic [RAD_W-1:0]   v_r, v_nxt, root_r, root_nxt, bit_r, bit_nxt, trial;
  logic [SCNT_W-1:0]  scnt_r, scnt_nxt;
  logic               valid_r, valid_nxt;
  logic [MEAN_W-1:0]  omean_r, omean_nxt;
  logic [STD_W-1:0]   ostd_r, ostd_nxt;
  logic               oovf_r, oovf_nxt;
  logic [CNT_W:0]     rem_sh;
  logic               ge;
  logic [SQ_W-1:0]    quot;
  logic [MSQ_W-1:0]   var_v;

  always_comb begin
    rem_sh = {rem_r, dvd_r[SQ_W-1]};
    ge     = (rem_sh >= {1'b0, n_r});
    quot   = {dvd_r[SQ_W-2:0], ge};
    trial  = root_r + bit_r;
    var_v  = (msq_r > meansq_r) ? (msq_r - meansq_r) : '0;

    state_nxt  = state_r;
    n_nxt      = n_r;
    sq_nxt     = sq_r;
    ovf_nxt    = ovf_r;
    zero_nxt   = zero_r;
    phase_nxt  = phase_r;
    rem_nxt    = rem_r;
    dvd_nxt    = dvd_r;
    dcnt_nxt   = dcnt_r;
    mean_nxt   = mean_r;
    msq_nxt    = msq_r;
    meansq_nxt = meansq_r;
    v_nxt      = v_r;
    root_nxt   = root_r;
    bit_nxt    = bit_r;
    scnt_nxt   = scnt_r;
    omean_nxt  = omean_r;
    ostd_nxt   = ostd_r;
    oovf_nxt   = oovf_r;
    valid_nxt  = valid_r && !out_pop;
    job_pop    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          n_nxt     = job.count;
          sq_nxt    = job.sq_sum;
          ovf_nxt   = job.ovf;
          zero_nxt  = (job.count == '0);
          dvd_nxt   = SQ_W'(job.sum);
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          phase_nxt = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = ge ? CNT_W'(rem_sh - {1'b0, n_r}) : CNT_W'(rem_sh);
        dvd_nxt  = quot;
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(SQ_W - 1)) begin
          rem_nxt  = '0;
          dcnt_nxt = '0;
          if (!phase_r) begin
            mean_nxt  = zero_r ? '0 : quot[MEAN_W-1:0];
            dvd_nxt   = sq_r;
            phase_nxt = 1'b1;
          end else begin
            msq_nxt   = zero_r ? '0 : quot[MSQ_W-1:0];
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        meansq_nxt = MSQ_W'(mean_r) * MSQ_W'(mean_r);
        state_nxt  = S_SUB;
      end
      S_SUB: begin
        v_nxt     = {var_v, {(RAD_W-MSQ_W){1'b0}}};
        root_nxt  = '0;
        bit_nxt   = RAD_W'(1) << (RAD_W - 2);
        scnt_nxt  = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (v_r >= trial) begin
          v_nxt    = v_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        scnt_nxt = scnt_r + SCNT_W'(1);
        if (scnt_r == SCNT_W'(ROOT_STEPS - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!valid_r || out_pop) begin
          omean_nxt = mean_r;
          ostd_nxt  = (|root_r[RAD_W-1:STD_W]) ? STD_MAX : root_r[STD_W-1:0];
          oovf_nxt  = ovf_r;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_empty = !valid_r;
    out_mean  = omean_r;
    out_std   = ostd_r;
    out_ovf   = oovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    n_r      <= n_nxt;
    sq_r     <= sq_nxt;
    ovf_r    <= ovf_nxt;
    zero_r   <= zero_nxt;
    phase_r  <= phase_nxt;
    rem_r    <= rem_nxt;
    dvd_r    <= dvd_nxt;
    dcnt_r   <= dcnt_nxt;
    mean_r   <= mean_nxt;
    msq_r    <= msq_nxt;
    meansq_r <= meansq_nxt;
    v_r      <= v_nxt;
    root_r   <= root_nxt;
    bit_r    <= bit_nxt;
    scnt_r   <= scnt_nxt;
    omean_r  <= omean_nxt;
    ostd_r   <= ostd_nxt;
    oovf_r   <= oovf_nxt;
  end

endmodule

`default_nettype wire

>>> sv/image_lightness_mean_stddev.sv
// Throughput: one pixel per cycle while in_full is low; in_full rises only while two finished images wait.
// After the last pixel, a result is computed by the bit-serial divider run twice and the 16-step root.
// The back end takes one image at a time; the front end keeps accumulating the next one.
// Reset (synchronous, rst_n low) clears accumulators, the job queue and the result slot.
`default_nettype none

module image_lightness_mean_stddev
  import ilms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output      logic              in_full,
  input  wire logic [PIX_W-1:0]  in_red,
  input  wire logic [PIX_W-1:0]  in_green,
  input  wire logic [PIX_W-1:0]  in_blue,
  input  wire logic              in_last_pixel,
  output      logic              out_empty,
  input  wire logic              out_pop,
  output      logic [MEAN_W-1:0] out_mean_lightness,
  output      logic [STD_W-1:0]  out_std_dev_q8,
  output      logic              out_overflow
);

  logic accept, push, pop, q_empty;
  job_t wr_job, rd_job;

  assign accept = in_push && !in_full;

  ilms_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .red        (in_red),
    .green      (in_green),
    .blue       (in_blue),
    .last_pixel (in_last_pixel),
    .job_push   (push),
    .job        (wr_job)
  );

  ilms_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (in_full),
    .empty  (q_empty)
  );

  ilms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job       (rd_job),
    .job_pop   (pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_mean  (out_mean_lightness),
    .out_std   (out_std_dev_q8),
    .out_ovf   (out_overflow)
  );

endmodule

`default_nettype wire

>>> sv/ilms_checker.sv
`default_nettype none
`include "assert_macros.svh"

module ilms_checker
  import ilms_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_push,
  input wire logic              in_full,
  input wire logic              in_last_pixel,
  input wire logic              out_empty,
  input wire logic              out_pop,
  input wire logic [MEAN_W-1:0] out_mean_lightness,
  input wire logic [STD_W-1:0]  out_std_dev_q8,
  input wire logic              out_overflow
);

  `ASSERT_NXT_ALWAYS(a_reset_clears, clk, !rst_n, out_empty && !in_full)
  `ASSERT_IMP(a_full_after_last, clk, rst_n, $rose(in_full), $past(in_push && in_last_pixel))
  `ASSERT_IMP(a_no_early_result, clk, rst_n, $fell(out_empty), $past(rst_n, 8))
  `ASSERT_NXT(a_result_holds, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_mean_lightness) && $stable(out_std_dev_q8) && $stable(out_overflow))

endmodule

bind image_lightness_mean_stddev ilms_checker u_ilms_checker (.*);

`default_nettype wire
